>>> rtl/ple_pkg.sv
// Package for the positional list engine: command and status codes and the
// control beat that the top level broadcasts to every list cell.
// Depends on nothing; used by ple_cell, positional_list_engine and ple_checker.
package ple_pkg;

   // Width of one stored value.
   localparam int VALUE_W = 16;

   // Command codes.
   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_BACK  = 3'd1;
   localparam logic [2:0] CMD_INS_AT    = 3'd2;
   localparam logic [2:0] CMD_RM_FRONT  = 3'd3;
   localparam logic [2:0] CMD_RM_BACK   = 3'd4;
   localparam logic [2:0] CMD_RM_AT     = 3'd5;
   localparam logic [2:0] CMD_APPEND    = 3'd6;

   // Status codes.
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_DUP    = 3'd1;
   localparam logic [2:0] ST_BADPOS = 3'd2;
   localparam logic [2:0] ST_EMPTY  = 3'd3;
   localparam logic [2:0] ST_FULL   = 3'd4;

   // Control beat sent to every cell during the execute cycle.
   typedef struct packed {
      logic               ins;
      logic               rm;
      logic [VALUE_W-1:0] value;
   } ple_shift_type;

endpackage

>>> rtl/positional_list_engine.sv
// Top level of the positional list engine: command capture, status decision
// and the row of ple_cell instances. Depends on ple_pkg and ple_cell.
//
// The cycle after start is taken, busy is high while every cell compares its
// entry with the command value and, if the command succeeds, the cells from
// the target position on shift by one place at once; the result then shows
// for one cycle with rsp_strobe high, and a new command may be started in
// that same cycle. The receiver cannot stall the result, so it must take it
// when it appears. Entries that were never written are never read back.
module positional_list_engine #(
   parameter int CAPACITY = 64,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_cmd,
   input  logic [CNT_W-1:0]             req_position,
   input  logic [ple_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_strobe,
   output logic [2:0]                   rsp_status,
   output logic [ple_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic [CNT_W-1:0]             rsp_entry_total
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   // Control and command registers.
   logic                         busy_ff;
   logic                         busy_in;
   logic [2:0]                   cmd_ff;
   logic [CNT_W-1:0]             pos_ff;
   logic [ple_pkg::VALUE_W-1:0]  val_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;

   // Result registers.
   logic                         strobe_ff;
   logic [2:0]                   status_ff;
   logic [2:0]                   status_in;
   logic [ple_pkg::VALUE_W-1:0]  removed_ff;
   logic [ple_pkg::VALUE_W-1:0]  removed_in;

   // Cell row signals.
   logic [ple_pkg::VALUE_W-1:0]  slot_vals [CAPACITY];
   logic [ple_pkg::VALUE_W-1:0]  taps      [CAPACITY];
   logic [CAPACITY-1:0]          hit_bits;
   logic [ple_pkg::VALUE_W-1:0]  tap_or;
   logic                         dup;
   logic [CNT_W-1:0]             at_sel;
   logic                         do_ins;
   logic                         do_rm;
   ple_pkg::ple_shift_type       ctrl;

   logic accept;
   assign accept = start && !busy_ff;

   // Target position for the command held in the execute cycle.
   always_comb begin
      unique case (cmd_ff) inside
         ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_RM_FRONT: at_sel = '0;
         ple_pkg::CMD_INS_BACK,  ple_pkg::CMD_APPEND:   at_sel = count_ff;
         ple_pkg::CMD_RM_BACK:                          at_sel = count_ff - ONE_CNT;
         default:                                       at_sel = pos_ff;
      endcase
   end

   // Gather duplicate hits and the entry offered for removal.
   always_comb begin
      tap_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tap_or = tap_or | taps[i];
      end
   end
   assign dup = |hit_bits;

   // Status decision and whether the row shifts.
   always_comb begin
      status_in = ple_pkg::ST_OK;
      do_ins    = 1'b0;
      do_rm     = 1'b0;
      unique case (cmd_ff) inside
         ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_BACK, ple_pkg::CMD_INS_AT: begin
            if (dup) begin
               status_in = ple_pkg::ST_DUP;
            end else if (at_sel > count_ff) begin
               status_in = ple_pkg::ST_BADPOS;
            end else if (count_ff == CAP_CNT) begin
               status_in = ple_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         ple_pkg::CMD_RM_FRONT, ple_pkg::CMD_RM_BACK, ple_pkg::CMD_RM_AT: begin
            if (count_ff == '0) begin
               status_in = ple_pkg::ST_EMPTY;
            end else if (at_sel >= count_ff) begin
               status_in = ple_pkg::ST_BADPOS;
            end else begin
               do_rm = 1'b1;
            end
         end
         ple_pkg::CMD_APPEND: begin
            if (count_ff == CAP_CNT) begin
               status_in = ple_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         default: begin
            status_in = ple_pkg::ST_OK;
         end
      endcase
   end

   // Shifts only happen in the execute cycle.
   assign ctrl.ins   = busy_ff && do_ins;
   assign ctrl.rm    = busy_ff && do_rm;
   assign ctrl.value = val_ff;

   assign removed_in = do_rm ? tap_or : '0;

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + ONE_CNT;
      end else if (ctrl.rm) begin
         count_in = count_ff - ONE_CNT;
      end
   end

   assign busy_in = accept ? 1'b1 : 1'b0;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         count_ff  <= count_in;
         strobe_ff <= busy_ff;
      end
   end

   // Command capture and result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      if (busy_ff) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
      end
   end

   // The row of cells.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ple_pkg::VALUE_W-1:0] left_v;
      logic [ple_pkg::VALUE_W-1:0] right_v;
      if (g == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_left
         assign left_v = slot_vals[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_right
         assign right_v = slot_vals[g+1];
      end
      ple_cell #(
         .IDX_W (CNT_W),
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .at          (at_sel),
         .count       (count_ff),
         .left_value  (left_v),
         .right_value (right_v),
         .slot_value  (slot_vals[g]),
         .match       (hit_bits[g]),
         .tap         (taps[g])
      );
   end

   assign busy              = busy_ff;
   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_entry_total   = count_ff;

endmodule

>>> rtl/ple_cell.sv
// One cell of the list: holds a single entry, compares it with the command
// value and shifts towards or away from the front when told to.
// Depends on ple_pkg.
module ple_cell #(
   parameter int IDX_W = 7,
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  ple_pkg::ple_shift_type       ctrl,
   input  logic [IDX_W-1:0]             at,
   input  logic [IDX_W-1:0]             count,
   input  logic [ple_pkg::VALUE_W-1:0]  left_value,
   input  logic [ple_pkg::VALUE_W-1:0]  right_value,
   output logic [ple_pkg::VALUE_W-1:0]  slot_value,
   output logic                         match,
   output logic [ple_pkg::VALUE_W-1:0]  tap
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [ple_pkg::VALUE_W-1:0] slot_ff;
   logic [ple_pkg::VALUE_W-1:0] slot_in;

   // Next entry: take the new value, the neighbour nearer the front on an
   // insert, or the neighbour nearer the back on a remove.
   always_comb begin
      slot_in = slot_ff;
      if (ctrl.ins) begin
         if (MY_IDX == at) begin
            slot_in = ctrl.value;
         end else if (MY_IDX > at) begin
            slot_in = left_value;
         end
      end else if (ctrl.rm && (MY_IDX >= at)) begin
         slot_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // Duplicate detection only counts entries that are in the list.
   assign match      = (MY_IDX < count) && (slot_ff == ctrl.value);
   // The addressed cell offers its entry for a remove.
   assign tap        = (MY_IDX == at) ? slot_ff : '0;
   assign slot_value = slot_ff;

endmodule

>>> rtl/ple_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine.
module ple_checker #(
   parameter int CAPACITY = 64,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic [2:0]                   rsp_status,
   input logic [ple_pkg::VALUE_W-1:0]  rsp_removed_value,
   input logic [CNT_W-1:0]             rsp_entry_total
);

   // A started command makes the block busy in the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command taken but busy did not rise");

   // The execute cycle is always followed by one result beat.
   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && !busy))
      else $error("execute cycle did not produce a result beat");

   // The entry count never exceeds the capacity.
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_entry_total <= CNT_W'(CAPACITY)))
      else $error("entry count beyond capacity");

   // Only a successful command can carry a removed value.
   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ple_pkg::ST_OK)) |-> (rsp_removed_value == '0))
      else $error("removed value on a refused command");

   // A refused command leaves the count as the previous result showed it.
   a_refused_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ple_pkg::ST_OK) && $past(rsp_strobe, 2))
      |-> (rsp_entry_total == $past(rsp_entry_total, 2)))
      else $error("refused command changed the entry count");

endmodule

bind positional_list_engine ple_checker #(
   .CAPACITY (CAPACITY),
   .CNT_W    (CNT_W)
) u_ple_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_removed_value (rsp_removed_value),
   .rsp_entry_total   (rsp_entry_total)
);

>>> tb/sv/tb_positional_list_engine.sv
// Self-checking testbench for positional_list_engine: directed and random command
// traffic, predicted by an ordered-list model in SystemVerilog and checked per beat.
// Depends on ple_pkg and the positional_list_engine RTL.
module tb_positional_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CAPACITY = 64;
   localparam int         CNT_W    = 7;
   localparam int         VALUE_W  = ple_pkg::VALUE_W;
   // Code 7 is unused by the block and must leave the list untouched.
   localparam logic [2:0] CMD_IDLE_CODE = 3'd7;

   // One result beat, as the block reports it.
   typedef struct packed {
      logic [2:0]         status;
      logic [VALUE_W-1:0] removed;
      logic [CNT_W-1:0]   total;
   } list_result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_cmd;
   logic [CNT_W-1:0]   req_position;
   logic [VALUE_W-1:0] req_value;
   logic               rsp_strobe;
   logic [2:0]         rsp_status;
   logic [VALUE_W-1:0] rsp_removed_value;
   logic [CNT_W-1:0]   rsp_entry_total;

   // Model of the list contents, front at index 0, and the results still owed.
   logic [VALUE_W-1:0] list_contents[$];
   list_result_type    owed_results[$];
   list_result_type    oldest_owed;

   int error_count;
   int beats_checked;
   int beats_sent;
   int burst_left;
   int deepest_list;
   int status_seen[5];

   positional_list_engine #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_total   (rsp_entry_total)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Applies one command to the list model and returns the result it must give.
   function automatic list_result_type apply_list_command(input logic [2:0] cmd,
                                                         input logic [CNT_W-1:0] pos,
                                                         input logic [VALUE_W-1:0] val);
      list_result_type res;
      bit              present;
      int              at;
      int              fill;
      res     = '0;
      present = 1'b0;
      fill    = list_contents.size();
      foreach (list_contents[i]) begin
         if (list_contents[i] == val) present = 1'b1;
      end
      res.status = ple_pkg::ST_OK;
      case (cmd)
         ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_BACK, ple_pkg::CMD_INS_AT: begin
            at = (cmd == ple_pkg::CMD_INS_FRONT) ? 0
               : (cmd == ple_pkg::CMD_INS_BACK) ? fill : int'(pos);
            // Duplicate wins over bad position, which wins over a full list.
            if (present) res.status = ple_pkg::ST_DUP;
            else if (at > fill) res.status = ple_pkg::ST_BADPOS;
            else if (fill >= CAPACITY) res.status = ple_pkg::ST_FULL;
            else list_contents.insert(at, val);
         end
         ple_pkg::CMD_RM_FRONT, ple_pkg::CMD_RM_BACK, ple_pkg::CMD_RM_AT: begin
            // An empty list is reported even when the position is also out of range.
            if (fill == 0) begin
               res.status = ple_pkg::ST_EMPTY;
            end else begin
               at = (cmd == ple_pkg::CMD_RM_FRONT) ? 0
                  : (cmd == ple_pkg::CMD_RM_BACK) ? fill - 1 : int'(pos);
               if (at >= fill) begin
                  res.status = ple_pkg::ST_BADPOS;
               end else begin
                  res.removed = list_contents[at];
                  list_contents.delete(at);
               end
            end
         end
         ple_pkg::CMD_APPEND: begin
            if (fill >= CAPACITY) res.status = ple_pkg::ST_FULL;
            else list_contents.push_back(val);
         end
         default: begin
         end
      endcase
      res.total = CNT_W'(list_contents.size());
      return res;
   endfunction

   // Sends one command beat and records its result once the block takes it.
   // Start is left high so that back-to-back beats need no second assignment.
   task automatic send_command(input logic [2:0] cmd, input logic [CNT_W-1:0] pos,
                               input logic [VALUE_W-1:0] val);
      req_cmd      <= cmd;
      req_position <= pos;
      req_value    <= val;
      if (!start) start <= 1'b1;
      do @(posedge clock); while (busy);
      owed_results.push_back(apply_list_command(cmd, pos, val));
      beats_sent++;
      if (list_contents.size() > deepest_list) deepest_list = list_contents.size();
      // Bursts of random length, separated by gaps that land on either cycle.
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // Checks every result beat against the oldest owed result.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (owed_results.size() == 0) begin
            $display("%0t: result beat with nothing owed: status %0d removed %h total %0d",
                     $realtime, rsp_status, rsp_removed_value, rsp_entry_total);
            error_count++;
         end else begin
            oldest_owed = owed_results.pop_front();
            beats_checked++;
            if (oldest_owed.status <= ple_pkg::ST_FULL) status_seen[oldest_owed.status]++;
            if (rsp_status !== oldest_owed.status) begin
               $display("%0t: status expected %0d, actual %0d",
                        $realtime, oldest_owed.status, rsp_status);
               error_count++;
            end
            if (rsp_removed_value !== oldest_owed.removed) begin
               $display("%0t: removed value expected %h, actual %h",
                        $realtime, oldest_owed.removed, rsp_removed_value);
               error_count++;
            end
            if (rsp_entry_total !== oldest_owed.total) begin
               $display("%0t: entry total expected %0d, actual %0d",
                        $realtime, oldest_owed.total, rsp_entry_total);
               error_count++;
            end
         end
      end
   end

   // Every kind of remove on an empty list, the unused code and a bad insert.
   task automatic test_empty_list();
      send_command(ple_pkg::CMD_RM_FRONT, 7'd0, 16'h0000);
      send_command(ple_pkg::CMD_RM_BACK, 7'd0, 16'h0000);
      send_command(ple_pkg::CMD_RM_AT, 7'd0, 16'h0000);
      send_command(ple_pkg::CMD_RM_AT, 7'd127, 16'hFFFF);
      send_command(CMD_IDLE_CODE, 7'd127, 16'hFFFF);
      send_command(ple_pkg::CMD_INS_AT, 7'd1, 16'h0005);
   endtask

   // Each insert flavour, at the front, the back, the middle and the end.
   task automatic test_insert_kinds();
      send_command(ple_pkg::CMD_INS_AT, 7'd0, 16'h0000);
      send_command(ple_pkg::CMD_INS_FRONT, 7'd0, 16'hFFFF);
      send_command(ple_pkg::CMD_INS_BACK, 7'd0, 16'h8000);
      send_command(ple_pkg::CMD_INS_AT, 7'd3, 16'h0001);
      send_command(ple_pkg::CMD_INS_AT, 7'd2, 16'h1234);
      // An unchecked append may store a value that is already present.
      send_command(ple_pkg::CMD_APPEND, 7'd0, 16'h0000);
   endtask

   // Duplicates are skipped by every checked insert, ahead of a bad position; then a new value at a bad position.
   task automatic test_duplicates();
      send_command(ple_pkg::CMD_INS_FRONT, 7'd0, 16'h0000);
      send_command(ple_pkg::CMD_INS_BACK, 7'd0, 16'hFFFF);
      send_command(ple_pkg::CMD_INS_AT, 7'd127, 16'h8000);
      send_command(ple_pkg::CMD_INS_AT, 7'd7, 16'h4321);
   endtask

   // Removes at each end, in the middle and one past the last entry.
   task automatic test_removes();
      send_command(ple_pkg::CMD_RM_AT, 7'd6, 16'h0000);
      send_command(ple_pkg::CMD_RM_AT, 7'd2, 16'h0000);
      send_command(ple_pkg::CMD_RM_FRONT, 7'd0, 16'h0000);
      send_command(ple_pkg::CMD_RM_BACK, 7'd0, 16'h0000);
      send_command(ple_pkg::CMD_RM_AT, 7'd64, 16'h0000);
   endtask

   // Fills the list to capacity, probes the refusals near capacity, then drains it.
   task automatic test_full_list();
      while (list_contents.size() < CAPACITY) begin
         send_command(ple_pkg::CMD_APPEND, 7'd0, VALUE_W'($urandom));
      end
      send_command(ple_pkg::CMD_APPEND, 7'd0, 16'hABCD);
      send_command(ple_pkg::CMD_INS_FRONT, 7'd0, 16'hABCD);
      send_command(ple_pkg::CMD_INS_BACK, 7'd0, 16'hABCD);
      send_command(ple_pkg::CMD_INS_AT, 7'd64, 16'hABCD);
      send_command(ple_pkg::CMD_INS_AT, 7'd65, 16'hABCD);
      send_command(ple_pkg::CMD_INS_FRONT, 7'd0, list_contents[CAPACITY-1]);
      send_command(ple_pkg::CMD_RM_AT, 7'd63, 16'h0000);
      send_command(ple_pkg::CMD_RM_AT, 7'd63, 16'h0000);
      while (list_contents.size() > 0) begin
         send_command(ple_pkg::CMD_RM_AT,
                      CNT_W'($urandom_range(0, list_contents.size() - 1)), 16'h0000);
      end
   endtask

   // Random traffic in phases that alternately grow and shrink the list.
   task automatic test_random_traffic();
      int                 roll;
      logic [2:0]         cmd;
      logic [CNT_W-1:0]   pos;
      logic [VALUE_W-1:0] val;
      for (int phase = 0; phase < 8; phase++) begin
         for (int n = 0; n < 120; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) cmd = CMD_IDLE_CODE;
            else if ((phase % 2 == 0) ? (roll < 70) : (roll < 35)) begin
               case ($urandom_range(0, 3))
                  0: cmd = ple_pkg::CMD_INS_FRONT;
                  1: cmd = ple_pkg::CMD_INS_BACK;
                  2: cmd = ple_pkg::CMD_INS_AT;
                  default: cmd = ple_pkg::CMD_APPEND;
               endcase
            end else begin
               case ($urandom_range(0, 2))
                  0: cmd = ple_pkg::CMD_RM_FRONT;
                  1: cmd = ple_pkg::CMD_RM_BACK;
                  default: cmd = ple_pkg::CMD_RM_AT;
               endcase
            end
            // Mostly positions that land in the list, sometimes anywhere in range.
            if ($urandom_range(0, 4) == 0) pos = CNT_W'($urandom_range(0, 127));
            else pos = CNT_W'($urandom_range(0, list_contents.size()));
            // A small pool of values makes duplicates common.
            if ($urandom_range(0, 2) == 0) val = VALUE_W'($urandom_range(0, 15));
            else val = VALUE_W'($urandom);
            send_command(cmd, pos, val);
         end
      end
   endtask

   // Stimulus sequence and end of run.
   initial begin
      int waited;
      reset        = 1'b1;
      start        = 1'b0;
      req_cmd      = ple_pkg::CMD_INS_FRONT;
      req_position = '0;
      req_value    = '0;
      error_count  = 0;
      burst_left   = 4;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_insert_kinds();
      test_duplicates();
      test_removes();
      test_full_list();
      test_random_traffic();

      start  <= 1'b0;
      waited = 0;
      while (owed_results.size() > 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (owed_results.size() > 0) begin
         $display("%0t: %0d results never arrived", $realtime, owed_results.size());
         error_count += owed_results.size();
      end

      $display("Ran %0d commands, checked %0d results; list reached %0d entries.",
               beats_sent, beats_checked, deepest_list);
      $display("Statuses seen: ok %0d, duplicate %0d, bad position %0d, empty %0d, full %0d.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
